[design/deq_pkg.sv]
package deq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [2:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [2:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [2:0] ACT_POP_BACK   = 3'd3;
  localparam logic [2:0] ACT_DUMP_FWD   = 3'd4;
  localparam logic [2:0] ACT_DUMP_BWD   = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // What the output register is loaded with
  localparam logic [1:0] OUT_DONE  = 2'd0;
  localparam logic [1:0] OUT_FULL  = 2'd1;
  localparam logic [1:0] OUT_EMPTY = 2'd2;
  localparam logic [1:0] OUT_DATA  = 2'd3;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } deq_req_t;

  typedef struct packed {
    logic signed [31:0] element;
    logic [1:0]         status;
    logic               last;
  } deq_rsp_t;

  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       take_front;
    logic       take_back;
    logic       walk_load;
    logic       walk_fwd;
    logic       walk_next;
    logic       rsp_load;
    logic [1:0] rsp_kind;
    logic       rsp_last;
  } deq_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic walk_last;
    logic rsp_free;
  } deq_sts_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
    if (i == IDX_W'(DEPTH - 1)) begin
      return '0;
    end
    return i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
    if (i == '0) begin
      return IDX_W'(DEPTH - 1);
    end
    return i - 1'b1;
  endfunction

endpackage

[design/deq_ctrl.sv]
module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic [2:0]        req_action,
  output logic              req_stall,
  input  deq_pkg::deq_sts_t sts,
  output deq_pkg::deq_cmd_t cmd
);
  import deq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  always_comb begin
    req_stall  = !((state == S_IDLE) && sts.rsp_free);
    accept     = req_valid && !req_stall;
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (req_action) inside
            ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
              cmd.rsp_load = 1'b1;
              cmd.rsp_last = 1'b1;
              if (sts.full) begin
                cmd.rsp_kind = OUT_FULL;
              end else begin
                cmd.rsp_kind   = OUT_DONE;
                cmd.push_front = (req_action == ACT_PUSH_FRONT);
                cmd.push_back  = (req_action == ACT_PUSH_BACK);
              end
            end
            ACT_POP_FRONT, ACT_POP_BACK: begin
              if (sts.empty) begin
                cmd.rsp_load = 1'b1;
                cmd.rsp_last = 1'b1;
                cmd.rsp_kind = OUT_EMPTY;
              end else begin
                cmd.take_front = (req_action == ACT_POP_FRONT);
                cmd.take_back  = (req_action == ACT_POP_BACK);
                state_next     = S_POP;
              end
            end
            ACT_DUMP_FWD, ACT_DUMP_BWD: begin
              if (sts.empty) begin
                cmd.rsp_load = 1'b1;
                cmd.rsp_last = 1'b1;
                cmd.rsp_kind = OUT_EMPTY;
              end else begin
                cmd.walk_load = 1'b1;
                cmd.walk_fwd  = (req_action == ACT_DUMP_FWD);
                state_next    = S_DUMP;
              end
            end
            default: ;  // unused codes: drop the item
          endcase
        end
      end
      S_POP: begin
        cmd.rsp_load = 1'b1;
        cmd.rsp_kind = OUT_DATA;
        cmd.rsp_last = 1'b1;
        state_next   = S_IDLE;
      end
      S_DUMP: begin
        if (sts.rsp_free) begin
          cmd.rsp_load = 1'b1;
          cmd.rsp_kind = OUT_DATA;
          cmd.rsp_last = sts.walk_last;
          if (sts.walk_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.walk_next = 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[design/deq_dpath.sv]
module deq_dpath (
  input  logic               clk,
  input  logic               rst,
  input  deq_pkg::deq_cmd_t  cmd,
  input  logic signed [31:0] req_value,
  output deq_pkg::deq_sts_t  sts,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output deq_pkg::deq_rsp_t  rsp
);
  import deq_pkg::*;

  logic [31:0]      ring [DEPTH];
  logic [31:0]      rd_data;
  logic [IDX_W-1:0] front;
  logic [IDX_W-1:0] back;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] walk_ptr;
  logic [CNT_W-1:0] walk_left;
  logic             walk_fwd;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  always_comb begin
    wr_en   = cmd.push_front || cmd.push_back;
    wr_addr = cmd.push_front ? idx_dec(front) : back;
    rd_en   = cmd.take_front || cmd.take_back || cmd.walk_load || cmd.walk_next;
    if (cmd.take_front) begin
      rd_addr = front;
    end else if (cmd.take_back) begin
      rd_addr = idx_dec(back);
    end else if (cmd.walk_load) begin
      rd_addr = cmd.walk_fwd ? front : idx_dec(back);
    end else begin
      rd_addr = walk_fwd ? idx_inc(walk_ptr) : idx_dec(walk_ptr);
    end
  end

  always_comb begin
    sts.empty     = (count == '0);
    sts.full      = (count == CNT_W'(DEPTH));
    sts.walk_last = (walk_left == CNT_W'(1));
    sts.rsp_free  = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wr_addr] <= req_value;
    end
    if (rd_en) begin
      rd_data <= ring[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      back      <= '0;
      count     <= '0;
      walk_left <= '0;
      walk_fwd  <= 1'b0;
    end else begin
      if (cmd.push_front || cmd.take_back) begin
        if (cmd.push_front) begin
          front <= idx_dec(front);
        end else begin
          back <= idx_dec(back);
        end
      end
      if (cmd.push_back) begin
        back <= idx_inc(back);
      end
      if (cmd.take_front) begin
        front <= idx_inc(front);
      end
      if (wr_en) begin
        count <= count + 1'b1;
      end else if (cmd.take_front || cmd.take_back) begin
        count <= count - 1'b1;
      end
      if (cmd.walk_load) begin
        walk_left <= count;
        walk_fwd  <= cmd.walk_fwd;
      end else if (cmd.walk_next) begin
        walk_left <= walk_left - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.walk_load || cmd.walk_next) begin
      walk_ptr <= rd_addr;
    end
  end

  // Output register: hold while stalled, clear valid after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rsp_load) begin
      rsp.last <= cmd.rsp_last;
      case (cmd.rsp_kind)
        OUT_DATA: begin
          rsp.element <= rd_data;
          rsp.status  <= ST_OK;
        end
        OUT_FULL: begin
          rsp.element <= '0;
          rsp.status  <= ST_FULL;
        end
        OUT_EMPTY: begin
          rsp.element <= '0;
          rsp.status  <= ST_EMPTY;
        end
        default: begin
          rsp.element <= '0;
          rsp.status  <= ST_OK;
        end
      endcase
    end
  end

endmodule

[design/double_ended_queue_unit.sv]
// Push, refused push and empty pop/dump: result valid in the cycle after the transfer.
// Pop and dump: the ring read is registered, then the output register is loaded. A dump
// of N elements then gives one per cycle while results flow; input is held off until the
// last element is loaded. Pushes sustain one item per cycle while results flow.
// Reset (synchronous, active high) empties the queue; ring contents are not cleared.
module double_ended_queue_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  deq_pkg::deq_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output deq_pkg::deq_rsp_t rsp
);
  import deq_pkg::*;

  deq_cmd_t cmd;
  deq_sts_t sts;

  deq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_action (req.action),
    .req_stall  (req_stall),
    .sts        (sts),
    .cmd        (cmd)
  );

  deq_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .req_value (req.value),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

[design/deq_checker.sv]
module deq_checker (
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input deq_pkg::deq_req_t req,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input deq_pkg::deq_rsp_t rsp
);
  import deq_pkg::*;

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid right after reset");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled response changed");

  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_stall |=> req_valid && $stable(req))
    else $error("stalled request changed");

  a_no_transfer_when_blocked: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |-> !(rsp_valid && rsp_stall))
    else $error("request taken while response is stalled");

  a_error_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last && rsp.element == '0)
    else $error("empty or full status not a lone zero result");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

[test/deq_checker.sv]
`timescale 1ns / 100ps

module deq_scoreboard (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  input  logic              req_stall,
  input  deq_pkg::deq_req_t req,
  input  logic              rsp_valid,
  input  logic              rsp_stall,
  input  deq_pkg::deq_rsp_t rsp,
  output int                fail_count,
  output int                due_count,
  output int                item_count,
  output int                result_count,
  output int                full_count,
  output int                empty_count
);
  import deq_pkg::*;

  logic signed [31:0] ring [DEPTH];
  logic [IDX_W-1:0]   head_q;
  logic [IDX_W-1:0]   tail_q;
  logic [CNT_W-1:0]   fill_q;
  deq_rsp_t           due_rsp [$];
  deq_rsp_t           want;

  initial begin
    fail_count   = 0;
    due_count    = 0;
    item_count   = 0;
    result_count = 0;
    full_count   = 0;
    empty_count  = 0;
    head_q       = '0;
    tail_q       = '0;
    fill_q       = '0;
  end

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return IDX_W'((int'(i) + 1) % DEPTH);
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return IDX_W'((int'(i) + DEPTH - 1) % DEPTH);
  endfunction

  function automatic deq_rsp_t mk_rsp(input logic signed [31:0] e, input logic [1:0] s,
                                      input logic l);
    deq_rsp_t r;
    r.element = e;
    r.status  = s;
    r.last    = l;
    return r;
  endfunction

  // Update the queue image and queue up every result this transfer causes
  task automatic apply_action(input deq_req_t r);
    logic [IDX_W-1:0] walk;
    int               n;
    case (r.action)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (fill_q == CNT_W'(DEPTH)) begin
          due_rsp.push_back(mk_rsp('0, ST_FULL, 1'b1));
        end else begin
          if (r.action == ACT_PUSH_FRONT) begin
            head_q       = ring_prev(head_q);
            ring[head_q] = r.value;
          end else begin
            ring[tail_q] = r.value;
            tail_q       = ring_next(tail_q);
          end
          fill_q = fill_q + 1'b1;
          due_rsp.push_back(mk_rsp('0, ST_OK, 1'b1));
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (fill_q == '0) begin
          due_rsp.push_back(mk_rsp('0, ST_EMPTY, 1'b1));
        end else begin
          if (r.action == ACT_POP_FRONT) begin
            walk   = head_q;
            head_q = ring_next(head_q);
          end else begin
            tail_q = ring_prev(tail_q);
            walk   = tail_q;
          end
          fill_q = fill_q - 1'b1;
          due_rsp.push_back(mk_rsp(ring[walk], ST_OK, 1'b1));
        end
      end
      ACT_DUMP_FWD, ACT_DUMP_BWD: begin
        if (fill_q == '0) begin
          due_rsp.push_back(mk_rsp('0, ST_EMPTY, 1'b1));
        end else begin
          n    = int'(fill_q);
          walk = (r.action == ACT_DUMP_FWD) ? head_q : ring_prev(tail_q);
          for (int k = 0; k < n; k++) begin
            due_rsp.push_back(mk_rsp(ring[walk], ST_OK, k == n - 1));
            walk = (r.action == ACT_DUMP_FWD) ? ring_next(walk) : ring_prev(walk);
          end
        end
      end
      default: begin
        // spare codes: no result, no state change
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      head_q = '0;
      tail_q = '0;
      fill_q = '0;
      due_rsp.delete();
    end else begin
      // results first: nothing accepted at this edge can answer at the same edge
      if (rsp_valid && !rsp_stall) begin
        result_count++;
        if (rsp.status == ST_FULL) full_count++;
        if (rsp.status == ST_EMPTY) empty_count++;
        if (due_rsp.size() == 0) begin
          $error("unexpected result: element %0d status %0d last %0b",
                 rsp.element, rsp.status, rsp.last);
          fail_count++;
        end else begin
          want = due_rsp.pop_front();
          if (rsp.element !== want.element) begin
            $error("element: expected %0d, got %0d", want.element, rsp.element);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, rsp.last);
            fail_count++;
          end
        end
      end
      if (req_valid && !req_stall) begin
        item_count++;
        apply_action(req);
      end
    end
    due_count = due_rsp.size();
  end

endmodule

[test/tb_double_ended_queue_unit.sv]
`timescale 1ns / 100ps

module tb_double_ended_queue_unit;
  import deq_pkg::*;

  localparam logic [2:0] ACT_SPARE_6 = 3'd6;
  localparam logic [2:0] ACT_SPARE_7 = 3'd7;
  localparam int ITEM_GOAL      = 420;
  localparam int SQUEEZE_CYCLES = 150;
  localparam int QUIET_LIMIT    = 1000;
  localparam int TAIL_CYCLES    = 20;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  deq_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  deq_rsp_t rsp;

  int fail_count;
  int due_count;
  int item_count;
  int result_count;
  int full_count;
  int empty_count;

  int sent_count;
  int quiet;
  bit steady;
  bit squeeze_req;

  double_ended_queue_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  deq_scoreboard u_check (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .req          (req),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .due_count    (due_count),
    .item_count   (item_count),
    .result_count (result_count),
    .full_count   (full_count),
    .empty_count  (empty_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [2:0] pick_push();
    return $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_BACK;
  endfunction

  function automatic logic [2:0] pick_pop();
    return $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_BACK;
  endfunction

  function automatic logic [2:0] pick_dump();
    return $urandom_range(0, 1) ? ACT_DUMP_FWD : ACT_DUMP_BWD;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input logic [2:0] act, input logic signed [31:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= deq_req_t'{action: act, value: val};
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (act <= ACT_DUMP_BWD) sent_count++;
    @(negedge clk);
  endtask

  // Result side: random hold-offs, plus one long squeeze on request
  initial begin
    int  r;
    int  len;
    bit  squeezed;
    rsp_stall = 1'b0;
    squeezed  = 1'b0;
    @(negedge clk);
    forever begin
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        rsp_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          rsp_stall <= 1'b0;
          len = $urandom_range(1, 4);
        end else if (r < 75) begin
          rsp_stall <= 1'b0;
          len = $urandom_range(30, 60);
        end else if (r < 95) begin
          rsp_stall <= 1'b1;
          len = $urandom_range(1, 3);
        end else begin
          rsp_stall <= 1'b1;
          len = $urandom_range(20, 60);
        end
        repeat (len) @(negedge clk);
      end
    end
  end

  // Abort on a long stretch with no transfer on either side
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("tb_double_ended_queue_unit: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int kind;
    int len;
    int r;
    bit first_burst;
    rst         = 1'b1;
    req_valid   = 1'b0;
    req         = '0;
    steady      = 1'b0;
    squeeze_req = 1'b0;
    sent_count  = 0;
    quiet       = 0;
    first_burst = 1'b1;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // empty queue
    send_item(ACT_POP_FRONT, pick_value());
    send_item(ACT_POP_BACK, pick_value());
    send_item(ACT_DUMP_FWD, pick_value());
    send_item(ACT_DUMP_BWD, pick_value());
    // extreme values at both ends, front index wraps below zero
    send_item(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_item(ACT_PUSH_BACK, 32'sh7fff_ffff);
    send_item(ACT_PUSH_FRONT, 32'sh5555_5555);
    send_item(ACT_PUSH_BACK, 32'shaaaa_aaaa);
    send_item(ACT_PUSH_FRONT, '0);
    send_item(ACT_PUSH_BACK, -32'sd1);
    send_item(ACT_DUMP_FWD, pick_value());
    send_item(ACT_DUMP_BWD, pick_value());
    send_item(ACT_SPARE_6, pick_value());
    send_item(ACT_SPARE_7, pick_value());
    // drain past empty
    repeat (3) begin
      send_item(ACT_POP_FRONT, pick_value());
      send_item(ACT_POP_BACK, pick_value());
    end
    send_item(ACT_POP_FRONT, pick_value());

    while (sent_count < ITEM_GOAL) begin
      if (!squeeze_req && sent_count >= 150) begin
        // block output while pushing back to back so the input stalls
        squeeze_req = 1'b1;
        steady      = 1'b1;
        repeat (40) begin
          if ($urandom_range(0, 4) == 0) send_item(pick_pop(), pick_value());
          else send_item(pick_push(), pick_value());
        end
      end
      kind        = first_burst ? 0 : $urandom_range(0, 9);
      first_burst = 1'b0;
      steady      = ($urandom_range(0, 4) == 0);
      case (kind)
        0, 1, 2: begin
          len = $urandom_range(12, 20);
          repeat (len) send_item(pick_push(), pick_value());
        end
        3, 4, 5: begin
          len = $urandom_range(8, 18);
          repeat (len) send_item(pick_pop(), pick_value());
        end
        6, 7, 8: begin
          len = $urandom_range(6, 14);
          repeat (len) begin
            r = $urandom_range(0, 19);
            if (r < 8) send_item(pick_push(), pick_value());
            else if (r < 14) send_item(pick_pop(), pick_value());
            else if (r < 18) send_item(pick_dump(), pick_value());
            else send_item($urandom_range(0, 1) ? ACT_SPARE_6 : ACT_SPARE_7, pick_value());
          end
        end
        default: begin
          len = $urandom_range(2, 4);
          repeat (len) send_item(pick_dump(), pick_value());
        end
      endcase
    end
    steady = 1'b0;
    req_valid <= 1'b0;

    while (due_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("run: %0d requests taken, %0d results checked (%0d refused pushes, %0d empty)",
             item_count, result_count, full_count, empty_count);
    $display("run: result side held off %0d cycles once to back up the request side",
             SQUEEZE_CYCLES);
    if (fail_count == 0 && due_count == 0) begin
      $display("tb_double_ended_queue_unit: clean");
    end else begin
      $display("tb_double_ended_queue_unit: errors");
    end
    $finish;
  end

endmodule

[files.f]
design/deq_pkg.sv
design/deq_ctrl.sv
design/deq_dpath.sv
design/double_ended_queue_unit.sv
design/deq_checker.sv
test/deq_checker.sv
test/tb_double_ended_queue_unit.sv
